FILE: rtl/core/hpq_pkg.sv
// Shared types, sizes, codes and the ranking function of the heap queue.
// Used by hpq_dp, hpq_ctrl and the top level under rtl/core; depends on nothing.
package hpq_pkg;

	localparam int NumEntries = 256;
	localparam int SlotW = $clog2(NumEntries);
	localparam int CntW = $clog2(NumEntries + 1);
	localparam int IdSpace = 256;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_EXTRACT = 2'd1;
	localparam logic [1:0] ACT_UPDATE = 2'd2;
	localparam logic [1:0] ACT_CLEAR = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_EMPTY = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_ABSENT = 3'd3;
	localparam logic [2:0] ST_PRESENT = 3'd4;

	// datapath operations, one per controller step
	localparam logic [4:0] OP_NONE = 5'd0;
	localparam logic [4:0] OP_LATCH = 5'd1;
	localparam logic [4:0] OP_ERR = 5'd2;
	localparam logic [4:0] OP_INS = 5'd3;
	localparam logic [4:0] OP_EXT_RD = 5'd4;
	localparam logic [4:0] OP_EXT_TAKE = 5'd5;
	localparam logic [4:0] OP_EXT_LOAD = 5'd6;
	localparam logic [4:0] OP_UPD_RD = 5'd7;
	localparam logic [4:0] OP_UPD_SLOT = 5'd8;
	localparam logic [4:0] OP_UPD_LOAD = 5'd9;
	localparam logic [4:0] OP_CLR = 5'd10;
	localparam logic [4:0] OP_UP_RD = 5'd11;
	localparam logic [4:0] OP_UP_MOVE = 5'd12;
	localparam logic [4:0] OP_DN_RDL = 5'd13;
	localparam logic [4:0] OP_DN_L = 5'd14;
	localparam logic [4:0] OP_DN_R = 5'd15;
	localparam logic [4:0] OP_DN_MOVE = 5'd16;
	localparam logic [4:0] OP_PLACE = 5'd17;
	localparam logic [4:0] OP_TOP_RD = 5'd18;
	localparam logic [4:0] OP_DONE = 5'd19;

	typedef struct packed {
		logic [7:0] id;
		logic [7:0] sat;
		logic [7:0] deg;
		logic [15:0] enr;
	} node_t;

	localparam int NodeW = $bits(node_t);

	typedef struct packed {
		logic [4:0] op;
		logic [2:0] status;
	} cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic present;
		logic full;
		logic empty;
		logic root;
		logic up_go;
		logic l_in;
		logic best_moved;
		logic sat_up;
		logic sat_down;
		logic out_free;
	} sts_t;

	// strict ranking: full ties never move
	function automatic logic outranks(node_t a, node_t b);
		logic r;
		if (a.sat != b.sat) begin
			r = a.sat > b.sat;
		end else if (a.deg != b.deg) begin
			r = a.deg > b.deg;
		end else begin
			r = a.enr > b.enr;
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/hpq_chan_if.sv
// Request and response channel interfaces of the heap queue.
// Depends on nothing.
interface hpq_req_if;
	logic valid;
	logic ready;
	logic [1:0] action;
	logic [7:0] entry_id;
	logic [7:0] saturation;
	logic [7:0] degree;
	logic [15:0] enrollment;
	modport source (output valid, action, entry_id, saturation, degree, enrollment,
		input ready);
	modport sink (input valid, action, entry_id, saturation, degree, enrollment,
		output ready);
endinterface

interface hpq_rsp_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [7:0] taken_id;
	logic [7:0] taken_saturation;
	logic [7:0] taken_degree;
	logic [15:0] taken_enrollment;
	logic [7:0] top_id;
	logic [7:0] top_saturation;
	logic [7:0] top_degree;
	logic [15:0] top_enrollment;
	logic is_empty;
	logic [8:0] entry_count;
	modport source (output valid, status, taken_id, taken_saturation, taken_degree,
		taken_enrollment, top_id, top_saturation, top_degree, top_enrollment, is_empty,
		entry_count, input ready);
	modport sink (input valid, status, taken_id, taken_saturation, taken_degree,
		taken_enrollment, top_id, top_saturation, top_degree, top_enrollment, is_empty,
		entry_count, output ready);
endinterface

FILE: rtl/core/hpq_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module hpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/core/hpq_dp.sv
// Heap datapath: slot and index memories, presence bits, count, sift registers
// and the response register. Depends on hpq_pkg, hpq_chan_if and hpq_ram.
module hpq_dp (
	input  logic           clk,
	input  logic           arst_n,
	hpq_req_if.sink        req,
	hpq_rsp_if.source      rsp,
	input  hpq_pkg::cmd_t  cmd,
	output hpq_pkg::sts_t  sts
);
	logic [1:0] act_q;
	hpq_pkg::node_t req_q;
	hpq_pkg::node_t cur_q;
	hpq_pkg::node_t best_q;
	hpq_pkg::node_t taken_q;
	logic [hpq_pkg::SlotW-1:0] i_q;
	logic [hpq_pkg::SlotW-1:0] best_slot_q;
	logic [7:0] old_sat_q;
	logic [2:0] status_q;
	logic [hpq_pkg::CntW-1:0] count_q;
	logic [hpq_pkg::IdSpace-1:0] present_q;
	logic out_valid_q;

	logic slot_we;
	logic [hpq_pkg::SlotW-1:0] slot_waddr;
	logic [hpq_pkg::SlotW-1:0] slot_raddr;
	hpq_pkg::node_t slot_wdata;
	hpq_pkg::node_t slot_rdata;
	logic idx_we;
	logic [7:0] idx_waddr;
	logic [hpq_pkg::SlotW-1:0] idx_wdata;
	logic [hpq_pkg::SlotW-1:0] idx_rdata;

	logic [hpq_pkg::SlotW-1:0] parent;
	logic [hpq_pkg::SlotW+1:0] left;
	logic [hpq_pkg::SlotW+1:0] right;
	logic [hpq_pkg::CntW-1:0] count_dec;

	assign parent = (i_q - 1'b1) >> 1;
	assign left = {1'b0, i_q, 1'b1};
	assign right = {1'b0, i_q, 1'b0} + (hpq_pkg::SlotW + 2)'(2);
	assign count_dec = count_q - 1'b1;

	hpq_ram #(.WIDTH(hpq_pkg::NodeW), .DEPTH(hpq_pkg::NumEntries)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	hpq_ram #(.WIDTH(hpq_pkg::SlotW), .DEPTH(hpq_pkg::IdSpace)) u_idx_ram (
		.clk   (clk),
		.we    (idx_we),
		.waddr (idx_waddr),
		.wdata (idx_wdata),
		.raddr (req_q.id),
		.rdata (idx_rdata)
	);

	always_comb begin
		slot_we = 1'b0;
		slot_waddr = i_q;
		slot_wdata = cur_q;
		slot_raddr = '0;
		idx_we = 1'b0;
		idx_waddr = cur_q.id;
		idx_wdata = i_q;
		case (cmd.op)
			hpq_pkg::OP_EXT_TAKE: slot_raddr = count_dec[hpq_pkg::SlotW-1:0];
			hpq_pkg::OP_UPD_SLOT: slot_raddr = idx_rdata;
			hpq_pkg::OP_UP_RD: slot_raddr = parent;
			hpq_pkg::OP_UP_MOVE: begin
				slot_we = 1'b1;
				slot_wdata = slot_rdata;
				idx_we = 1'b1;
				idx_waddr = slot_rdata.id;
			end
			hpq_pkg::OP_DN_RDL: slot_raddr = left[hpq_pkg::SlotW-1:0];
			hpq_pkg::OP_DN_L: slot_raddr = right[hpq_pkg::SlotW-1:0];
			hpq_pkg::OP_DN_MOVE: begin
				slot_we = 1'b1;
				slot_wdata = best_q;
				idx_we = 1'b1;
				idx_waddr = best_q.id;
			end
			hpq_pkg::OP_PLACE: begin
				slot_we = 1'b1;
				idx_we = 1'b1;
			end
			default: slot_raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			present_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				hpq_pkg::OP_INS: begin
					count_q <= count_q + 1'b1;
					present_q[req_q.id] <= 1'b1;
				end
				hpq_pkg::OP_EXT_TAKE: begin
					count_q <= count_dec;
					present_q[slot_rdata.id] <= 1'b0;
				end
				hpq_pkg::OP_CLR: begin
					count_q <= '0;
					present_q <= '0;
				end
				hpq_pkg::OP_DONE: out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			hpq_pkg::OP_LATCH: begin
				act_q <= req.action;
				req_q <= '{req.entry_id, req.saturation, req.degree, req.enrollment};
				taken_q <= '0;
				status_q <= hpq_pkg::ST_OK;
			end
			hpq_pkg::OP_ERR: status_q <= cmd.status;
			hpq_pkg::OP_INS: begin
				cur_q <= req_q;
				i_q <= count_q[hpq_pkg::SlotW-1:0];
			end
			hpq_pkg::OP_EXT_TAKE: taken_q <= slot_rdata;
			hpq_pkg::OP_EXT_LOAD: begin
				cur_q <= slot_rdata;
				i_q <= '0;
			end
			hpq_pkg::OP_UPD_SLOT: i_q <= idx_rdata;
			hpq_pkg::OP_UPD_LOAD: begin
				old_sat_q <= slot_rdata.sat;
				cur_q <= '{slot_rdata.id, req_q.sat, slot_rdata.deg, slot_rdata.enr};
			end
			hpq_pkg::OP_UP_MOVE: i_q <= parent;
			hpq_pkg::OP_DN_L: begin
				if (hpq_pkg::outranks(slot_rdata, cur_q)) begin
					best_q <= slot_rdata;
					best_slot_q <= left[hpq_pkg::SlotW-1:0];
				end else begin
					best_q <= cur_q;
					best_slot_q <= i_q;
				end
			end
			hpq_pkg::OP_DN_R: begin
				if ((right < (hpq_pkg::SlotW + 2)'(count_q))
						&& hpq_pkg::outranks(slot_rdata, best_q)) begin
					best_q <= slot_rdata;
					best_slot_q <= right[hpq_pkg::SlotW-1:0];
				end
			end
			hpq_pkg::OP_DN_MOVE: i_q <= best_slot_q;
			hpq_pkg::OP_DONE: begin
				rsp.status <= status_q;
				rsp.taken_id <= taken_q.id;
				rsp.taken_saturation <= taken_q.sat;
				rsp.taken_degree <= taken_q.deg;
				rsp.taken_enrollment <= taken_q.enr;
				rsp.top_id <= (count_q == '0) ? '0 : slot_rdata.id;
				rsp.top_saturation <= (count_q == '0) ? '0 : slot_rdata.sat;
				rsp.top_degree <= (count_q == '0) ? '0 : slot_rdata.deg;
				rsp.top_enrollment <= (count_q == '0) ? '0 : slot_rdata.enr;
				rsp.is_empty <= count_q == '0;
				rsp.entry_count <= count_q;
			end
			default: ;
		endcase
	end

	assign rsp.valid = out_valid_q;

	always_comb begin
		sts.action = act_q;
		sts.present = present_q[req_q.id];
		sts.full = count_q >= hpq_pkg::CntW'(hpq_pkg::NumEntries);
		sts.empty = count_q == '0;
		sts.root = i_q == '0;
		sts.up_go = hpq_pkg::outranks(cur_q, slot_rdata);
		sts.l_in = left < (hpq_pkg::SlotW + 2)'(count_q);
		sts.best_moved = best_slot_q != i_q;
		sts.sat_up = req_q.sat > old_sat_q;
		sts.sat_down = req_q.sat < old_sat_q;
		sts.out_free = !out_valid_q || rsp.ready;
	end
endmodule

FILE: rtl/core/hpq_ctrl.sv
// Heap controller: sequences insert, extract, update and clear over the datapath.
// Depends on hpq_pkg.
module hpq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  hpq_pkg::sts_t  sts,
	output hpq_pkg::cmd_t  cmd
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DEC = 4'd1;
	localparam logic [3:0] S_EXT_TAKE = 4'd2;
	localparam logic [3:0] S_EXT_CHK = 4'd3;
	localparam logic [3:0] S_UPD_SLOT = 4'd4;
	localparam logic [3:0] S_UPD_LOAD = 4'd5;
	localparam logic [3:0] S_UPD_DIR = 4'd6;
	localparam logic [3:0] S_UP_CHK = 4'd7;
	localparam logic [3:0] S_UP_CMP = 4'd8;
	localparam logic [3:0] S_DN_CHK = 4'd9;
	localparam logic [3:0] S_DN_L = 4'd10;
	localparam logic [3:0] S_DN_R = 4'd11;
	localparam logic [3:0] S_DN_DEC = 4'd12;
	localparam logic [3:0] S_PLACE = 4'd13;
	localparam logic [3:0] S_TOP = 4'd14;
	localparam logic [3:0] S_DONE = 4'd15;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign req_ready = state_q == S_IDLE;

	always_comb begin
		state_d = state_q;
		cmd.op = hpq_pkg::OP_NONE;
		cmd.status = hpq_pkg::ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.op = hpq_pkg::OP_LATCH;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				unique case (sts.action)
					hpq_pkg::ACT_INSERT: begin
						if (sts.present) begin
							cmd = '{hpq_pkg::OP_ERR, hpq_pkg::ST_PRESENT};
							state_d = S_TOP;
						end else if (sts.full) begin
							cmd = '{hpq_pkg::OP_ERR, hpq_pkg::ST_FULL};
							state_d = S_TOP;
						end else begin
							cmd.op = hpq_pkg::OP_INS;
							state_d = S_UP_CHK;
						end
					end
					hpq_pkg::ACT_EXTRACT: begin
						if (sts.empty) begin
							cmd = '{hpq_pkg::OP_ERR, hpq_pkg::ST_EMPTY};
							state_d = S_TOP;
						end else begin
							cmd.op = hpq_pkg::OP_EXT_RD;
							state_d = S_EXT_TAKE;
						end
					end
					hpq_pkg::ACT_UPDATE: begin
						if (!sts.present) begin
							cmd = '{hpq_pkg::OP_ERR, hpq_pkg::ST_ABSENT};
							state_d = S_TOP;
						end else begin
							cmd.op = hpq_pkg::OP_UPD_RD;
							state_d = S_UPD_SLOT;
						end
					end
					default: begin
						cmd.op = hpq_pkg::OP_CLR;
						state_d = S_TOP;
					end
				endcase
			end
			S_EXT_TAKE: begin
				cmd.op = hpq_pkg::OP_EXT_TAKE;
				state_d = S_EXT_CHK;
			end
			S_EXT_CHK: begin
				if (sts.empty) begin
					state_d = S_TOP;
				end else begin
					cmd.op = hpq_pkg::OP_EXT_LOAD;
					state_d = S_DN_CHK;
				end
			end
			S_UPD_SLOT: begin
				cmd.op = hpq_pkg::OP_UPD_SLOT;
				state_d = S_UPD_LOAD;
			end
			S_UPD_LOAD: begin
				cmd.op = hpq_pkg::OP_UPD_LOAD;
				state_d = S_UPD_DIR;
			end
			S_UPD_DIR: begin
				// an unchanged saturation leaves the stored entry as it is
				if (sts.sat_up) begin
					state_d = S_UP_CHK;
				end else if (sts.sat_down) begin
					state_d = S_DN_CHK;
				end else begin
					state_d = S_TOP;
				end
			end
			S_UP_CHK: begin
				if (sts.root) begin
					state_d = S_PLACE;
				end else begin
					cmd.op = hpq_pkg::OP_UP_RD;
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (sts.up_go) begin
					cmd.op = hpq_pkg::OP_UP_MOVE;
					state_d = S_UP_CHK;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_DN_CHK: begin
				if (!sts.l_in) begin
					state_d = S_PLACE;
				end else begin
					cmd.op = hpq_pkg::OP_DN_RDL;
					state_d = S_DN_L;
				end
			end
			S_DN_L: begin
				cmd.op = hpq_pkg::OP_DN_L;
				state_d = S_DN_R;
			end
			S_DN_R: begin
				cmd.op = hpq_pkg::OP_DN_R;
				state_d = S_DN_DEC;
			end
			S_DN_DEC: begin
				if (sts.best_moved) begin
					cmd.op = hpq_pkg::OP_DN_MOVE;
					state_d = S_DN_CHK;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				cmd.op = hpq_pkg::OP_PLACE;
				state_d = S_TOP;
			end
			S_TOP: begin
				cmd.op = hpq_pkg::OP_TOP_RD;
				state_d = S_DONE;
			end
			S_DONE: begin
				// hold until the response register is free
				if (sts.out_free) begin
					cmd.op = hpq_pkg::OP_DONE;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

FILE: rtl/core/indexed_max_heap_priority_queue_unit.sv
// Top level of the indexed max-heap queue: controller plus datapath.
// Depends on hpq_pkg, hpq_chan_if, hpq_ctrl and hpq_dp.
//
//   channel  dir  payload
//   req      in   action, entry_id, saturation, degree, enrollment
//   rsp      out  status, taken_*, top_*, is_empty, entry_count
//
// One item at a time: a new request is accepted only in the idle state, once the
// previous item is through. Errors and clear go straight to the top read; insert climbs
// level by level, extract descends level by level (left child read, then right child),
// and update climbs or descends. The single read port of the slot RAM serializes reads.
// Reset clears the count and all presence bits at once; no sweep is needed.
// A waiting response does not block the next request; only its final step waits.
module indexed_max_heap_priority_queue_unit (
	input  logic      clk,
	input  logic      arst_n,
	hpq_req_if.sink   req,
	hpq_rsp_if.source rsp
);
	hpq_pkg::cmd_t cmd;
	hpq_pkg::sts_t sts;

	hpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	hpq_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.sts    (sts)
	);
endmodule

FILE: verif/indexed_max_heap_priority_queue_unit_tb.sv
// Testbench of the indexed max-heap queue: drives requests, predicts each response
// with its own heap model, checks every field. Uses hpq_pkg, hpq_chan_if and the DUT.
`timescale 1ns / 100ps

module indexed_max_heap_priority_queue_unit_tb;

	typedef struct {
		logic [2:0] status;
		hpq_pkg::node_t taken;
		hpq_pkg::node_t top;
		logic is_empty;
		logic [8:0] entry_count;
	} heap_reply_t;

	class heap_scoreboard;
		hpq_pkg::node_t heap[hpq_pkg::NumEntries];
		bit held[hpq_pkg::IdSpace];
		int unsigned pos[hpq_pkg::IdSpace];
		int unsigned fill;
		heap_reply_t pending[$];
		int errors;

		function bit higher(hpq_pkg::node_t a, hpq_pkg::node_t b);
			if (a.sat != b.sat) return a.sat > b.sat;
			if (a.deg != b.deg) return a.deg > b.deg;
			return a.enr > b.enr;
		endfunction

		function void swap_slots(int unsigned i, int unsigned j);
			hpq_pkg::node_t t;
			t = heap[i];
			heap[i] = heap[j];
			heap[j] = t;
			pos[heap[i].id] = i;
			pos[heap[j].id] = j;
		endfunction

		function void climb(int unsigned i);
			int unsigned p;
			while (i > 0) begin
				p = (i - 1) / 2;
				if (!higher(heap[i], heap[p])) break;
				swap_slots(i, p);
				i = p;
			end
		endfunction

		function void descend(int unsigned i);
			int unsigned b;
			forever begin
				b = i;
				if (2 * i + 1 < fill && higher(heap[2 * i + 1], heap[b])) b = 2 * i + 1;
				if (2 * i + 2 < fill && higher(heap[2 * i + 2], heap[b])) b = 2 * i + 2;
				if (b == i) break;
				swap_slots(i, b);
				i = b;
			end
		endfunction

		function void note_request(logic [1:0] act, logic [7:0] id, logic [7:0] sat,
				logic [7:0] deg, logic [15:0] enr);
			heap_reply_t r;
			logic [7:0] old;
			r.status = hpq_pkg::ST_OK;
			r.taken = '0;
			r.top = '0;
			case (act)
				hpq_pkg::ACT_INSERT: begin
					if (held[id]) r.status = hpq_pkg::ST_PRESENT;
					else if (fill >= hpq_pkg::NumEntries) r.status = hpq_pkg::ST_FULL;
					else begin
						heap[fill] = '{id: id, sat: sat, deg: deg, enr: enr};
						held[id] = 1;
						pos[id] = fill;
						fill++;
						climb(fill - 1);
					end
				end
				hpq_pkg::ACT_EXTRACT: begin
					if (fill == 0) r.status = hpq_pkg::ST_EMPTY;
					else begin
						r.taken = heap[0];
						held[heap[0].id] = 0;
						fill--;
						if (fill > 0) begin
							heap[0] = heap[fill];
							pos[heap[0].id] = 0;
							descend(0);
						end
					end
				end
				hpq_pkg::ACT_UPDATE: begin
					if (!held[id]) r.status = hpq_pkg::ST_ABSENT;
					else begin
						old = heap[pos[id]].sat;
						heap[pos[id]].sat = sat;
						if (sat > old) climb(pos[id]);
						else if (sat < old) descend(pos[id]);
					end
				end
				default: begin
					fill = 0;
					foreach (held[k]) held[k] = 0;
				end
			endcase
			if (fill > 0) r.top = heap[0];
			r.is_empty = (fill == 0);
			r.entry_count = 9'(fill);
			pending.push_back(r);
		endfunction

		function void cmp(string name, logic [15:0] e, logic [15:0] a);
			if (e != a) begin
				$error("%s: expected %0h, got %0h", name, e, a);
				errors++;
			end
		endfunction

		function void check_reply(heap_reply_t a);
			heap_reply_t e;
			if (pending.size() == 0) begin
				$error("response with no request outstanding");
				errors++;
				return;
			end
			e = pending.pop_front();
			cmp("status", 16'(e.status), 16'(a.status));
			cmp("taken_id", 16'(e.taken.id), 16'(a.taken.id));
			cmp("taken_saturation", 16'(e.taken.sat), 16'(a.taken.sat));
			cmp("taken_degree", 16'(e.taken.deg), 16'(a.taken.deg));
			cmp("taken_enrollment", e.taken.enr, a.taken.enr);
			cmp("top_id", 16'(e.top.id), 16'(a.top.id));
			cmp("top_saturation", 16'(e.top.sat), 16'(a.top.sat));
			cmp("top_degree", 16'(e.top.deg), 16'(a.top.deg));
			cmp("top_enrollment", e.top.enr, a.top.enr);
			cmp("is_empty", 16'(e.is_empty), 16'(a.is_empty));
			cmp("entry_count", 16'(e.entry_count), 16'(a.entry_count));
		endfunction
	endclass

	localparam int StallLimit = 2000;

	logic clk = 0;
	logic arst_n = 0;
	hpq_req_if req ();
	hpq_rsp_if rsp ();
	heap_scoreboard board = new();
	int idle_cycles = 0;
	int rsp_wait = 0;

	indexed_max_heap_priority_queue_unit i_dut (.clk(clk), .arst_n(arst_n), .req(req),
		.rsp(rsp));

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	initial begin
		req.valid = 0;
		req.action = hpq_pkg::ACT_INSERT;
		req.entry_id = '0;
		req.saturation = '0;
		req.degree = '0;
		req.enrollment = '0;
		rsp.ready = 0;
	end

	task automatic send(logic [1:0] act, logic [7:0] id, logic [7:0] sat,
			logic [7:0] deg, logic [15:0] enr);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			req.valid <= 0;
			repeat (gap) @(negedge clk);
		end
		req.valid <= 1;
		req.action <= act;
		req.entry_id <= id;
		req.saturation <= sat;
		req.degree <= deg;
		req.enrollment <= enr;
		do @(posedge clk); while (!req.ready);
		board.note_request(act, id, sat, deg, enr);
		@(negedge clk);
	endtask

	function automatic logic [7:0] rnd8();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [15:0] rnd16();
		return 16'($urandom_range(0, 65535));
	endfunction

	// ids come from a small pool so that duplicates, absences and hits are all common
	function automatic logic [7:0] pick_id(int pool);
		return (pool >= 256) ? rnd8() : 8'($urandom_range(0, pool - 1));
	endfunction

	// hold ready low for a drawn number of cycles of each waiting response
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 0;
		end else if (rsp_wait > 0) begin
			rsp.ready <= 0;
			if (rsp.valid) rsp_wait--;
		end else begin
			rsp.ready <= 1;
		end
	end

	always @(posedge clk) begin
		heap_reply_t a;
		if (arst_n && rsp.valid && rsp.ready) begin
			a.status = rsp.status;
			a.taken = '{rsp.taken_id, rsp.taken_saturation, rsp.taken_degree,
				rsp.taken_enrollment};
			a.top = '{rsp.top_id, rsp.top_saturation, rsp.top_degree, rsp.top_enrollment};
			a.is_empty = rsp.is_empty;
			a.entry_count = rsp.entry_count;
			board.check_reply(a);
			rsp_wait = $urandom_range(0, 5);
		end
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= StallLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int r;
		int pool;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// directed: empty extract, absent update, extremes, ties, duplicate, clear
		send(hpq_pkg::ACT_EXTRACT, 8'h00, 8'h00, 8'h00, 16'h0000);
		send(hpq_pkg::ACT_UPDATE, 8'hff, 8'hff, 8'h00, 16'h0000);
		send(hpq_pkg::ACT_INSERT, 8'h00, 8'h00, 8'h00, 16'h0000);
		send(hpq_pkg::ACT_INSERT, 8'hff, 8'hff, 8'hff, 16'hffff);
		send(hpq_pkg::ACT_INSERT, 8'h10, 8'h80, 8'h80, 16'h8000);
		send(hpq_pkg::ACT_INSERT, 8'h11, 8'h80, 8'h80, 16'h8000);
		send(hpq_pkg::ACT_INSERT, 8'h12, 8'h80, 8'h80, 16'h8001);
		send(hpq_pkg::ACT_INSERT, 8'h13, 8'h80, 8'h81, 16'h0000);
		send(hpq_pkg::ACT_INSERT, 8'h10, 8'h01, 8'h01, 16'h0001);
		send(hpq_pkg::ACT_UPDATE, 8'h00, 8'hff, 8'h00, 16'h0000);
		send(hpq_pkg::ACT_UPDATE, 8'hff, 8'h00, 8'h00, 16'h0000);
		send(hpq_pkg::ACT_UPDATE, 8'h12, 8'h80, 8'h00, 16'h0000);
		send(hpq_pkg::ACT_EXTRACT, 8'h00, 8'h00, 8'h00, 16'h0000);
		send(hpq_pkg::ACT_EXTRACT, 8'h00, 8'h00, 8'h00, 16'h0000);
		send(hpq_pkg::ACT_CLEAR, 8'h00, 8'h00, 8'h00, 16'h0000);
		send(hpq_pkg::ACT_UPDATE, 8'h13, 8'h05, 8'h00, 16'h0000);
		// fill to capacity, then insert an id already held (reported as present, not full) and empty it again
		for (int k = 0; k < 256; k++)
			send(hpq_pkg::ACT_INSERT, k[7:0], rnd8(), rnd8(), rnd16());
		send(hpq_pkg::ACT_INSERT, 8'h42, 8'h01, 8'h01, 16'h0001);
		send(hpq_pkg::ACT_UPDATE, 8'h42, 8'h00, 8'h00, 16'h0000);
		send(hpq_pkg::ACT_CLEAR, 8'h00, 8'h00, 8'h00, 16'h0000);
		// random: mostly inserts and updates; inserts often draw small key ranges to force ties
		for (int n = 0; n < 275; n++) begin
			r = $urandom_range(0, 99);
			pool = ($urandom_range(0, 3) == 0) ? 256 : 24;
			if (r < 40)
				send(hpq_pkg::ACT_INSERT, pick_id(pool),
					($urandom_range(0, 1)) ? rnd8() : 8'($urandom_range(0, 3)),
					($urandom_range(0, 1)) ? rnd8() : 8'($urandom_range(0, 1)),
					($urandom_range(0, 1)) ? rnd16() : 16'($urandom_range(0, 1)));
			else if (r < 65)
				send(hpq_pkg::ACT_EXTRACT, rnd8(), rnd8(), rnd8(), rnd16());
			else if (r < 97)
				send(hpq_pkg::ACT_UPDATE, pick_id(pool), rnd8(), rnd8(), rnd16());
			else
				send(hpq_pkg::ACT_CLEAR, rnd8(), rnd8(), rnd8(), rnd16());
		end
		req.valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (board.errors == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
